>>> hw/rtl/so3em_pkg.sv
// Shared constants, the pipeline item type and elaboration-time table functions
// for the rotation-vector to quaternion exponential map. No dependencies.
package so3em_pkg;

    localparam int IN_FRAC_BITS_DEF  = 27;
    localparam int OUT_FRAC_BITS_DEF = 30;
    localparam int CORDIC_STAGES_DEF = 32;

    localparam logic [63:0] ONE_Q61     = 64'h2000_0000_0000_0000;
    localparam logic [63:0] PI_Q61      = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] HALF_PI_Q61 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] TWO_PI_Q61  = 64'hC90F_DAA2_2168_C234;

    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 62;
    localparam int ANGLE_STEPS = 33;

    // register map (index of a 32-bit register, byte address 4*index)
    localparam logic       REG_THRESH   = 1'b0;
    localparam logic [30:0] THRESH_RESET = 31'd1;

    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][31:0]       mag;
        logic [2:0][63:0]       sq;
        logic [63:0]            rad;
        logic [63:0]            root;
        logic                   ident;
        logic [63:0]            r;
        logic [2:0][32:0]       rem;
        logic [2:0][61:0]       quo;
        logic                   flip;
        logic [63:0]            cx;
        logic [63:0]            cy;
        logic [63:0]            cz;
        logic                   cneg;
        logic                   sneg;
        logic [63:0]            cmag;
        logic [63:0]            smag;
        logic [2:0][3:0][63:0]  pp;
        logic [2:0][63:0]       prod;
        logic [3:0][31:0]       quat;
    } item_t;

    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] f;
        f = {64'b0, a} * {64'b0, b};
        return f[124:61];
    endfunction

    // truncated quotient by shift and subtract, used for table constants only
    function automatic logic [63:0] div_const(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // arctan(2^-i) in Q.61 from the odd power series, truncated term by term
    function automatic logic [63:0] arc_entry(input int i);
        logic [63:0] acc;
        logic [63:0] d;
        int          sh;
        acc = 64'd0;
        if (i == 0)
        begin
            acc = PI_Q61 >> 2;
        end
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                sh = i * (2 * k + 1);
                d  = 64'(2 * k + 1);
                if (sh <= 61)
                begin
                    if ((k & 1) == 1)
                        acc = acc - div_const(ONE_Q61 >> sh, d);
                    else
                        acc = acc + div_const(ONE_Q61 >> sh, d);
                end
            end
        end
        return acc;
    endfunction

    // reciprocal of the CORDIC gain, largest y with y*y*gain^2 <= 1
    function automatic logic [63:0] inv_gain(input int stages);
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] t;
        p = ONE_Q61;
        y = 64'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (i < stages)
                p = p + (p >> (2 * i));
        end
        for (int b = 60; b >= 0; b--)
        begin
            t = y | (64'd1 << b);
            if (mul_q61(mul_q61(t, t), p) <= ONE_Q61)
                y = t;
        end
        return y;
    endfunction

    function automatic logic [63:0] mod_double(input logic [63:0] r);
        logic [63:0] d;
        d = TWO_PI_Q61 - r;
        return (r >= d) ? (r - d) : (r + r);
    endfunction

endpackage

>>> hw/rtl/so3em_round.sv
// Rounds a Q.61 magnitude to Q.OUT_FRAC_BITS half away from zero, saturates
// and applies the sign. Depends on nothing.
module so3em_round #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic        neg,
    input  logic [63:0] mag,
    output logic [31:0] value
);

    localparam int          SH  = 61 - OUT_FRAC_BITS;
    localparam logic [63:0] CAP = (OUT_FRAC_BITS >= 31) ? 64'h7FFF_FFFF
                                                        : (64'd1 << OUT_FRAC_BITS);

    logic [63:0] rnd;
    logic [63:0] sat;

    generate
        if (SH > 0)
        begin : g_down
            assign rnd = (mag + (64'd1 << (SH - 1))) >> SH;
        end
        else if (SH == 0)
        begin : g_same
            assign rnd = mag;
        end
        else
        begin : g_up
            localparam int NSH = -SH;
            assign rnd = mag << NSH;
        end
    endgenerate

    assign sat   = (rnd > CAP) ? CAP : rnd;
    assign value = neg ? (~sat[31:0] + 32'd1) : sat[31:0];

endmodule

>>> hw/rtl/so3_exp_map.sv
// Rotation vector (Q4.27) to unit quaternion (Q1.30): exponential map of SO(3).
// Depends on so3em_pkg and so3em_round.
//
// The block takes one rotation vector per cycle while the output is not stalled, and
// returns one quaternion per vector, in order. Most of the pipeline is the chain of
// one-step-per-stage units: a 32-stage integer square root, the modulo-2*pi reduction
// of the half angle running side by side with the three restoring dividers for the
// direction ratios, and the rotation CORDIC. The whole pipeline holds while a
// finished quaternion waits at the output. Angles below small_angle_threshold (APB
// byte address 0) give the identity quaternion with tuser high.
module so3_exp_map #(
    parameter int IN_FRAC_BITS  = so3em_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = so3em_pkg::OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = so3em_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // omega_x, omega_y, omega_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic         m_axis_tuser    // identity_taken
);

    localparam int MOD_STEPS = so3em_pkg::ANGLE_STEPS + 60 - IN_FRAC_BITS;
    localparam int DM_STAGES = (MOD_STEPS > so3em_pkg::DIV_STEPS) ? MOD_STEPS
                                                                  : so3em_pkg::DIV_STEPS;
    localparam int SQ0   = 2;
    localparam int TH    = SQ0 + so3em_pkg::SQRT_STEPS;
    localparam int DM0   = TH + 1;
    localparam int FD    = DM0 + DM_STAGES;
    localparam int CR0   = FD + 1;
    localparam int SG    = CR0 + CORDIC_STAGES;
    localparam int PA    = SG + 1;
    localparam int PB    = PA + 1;
    localparam int OUT   = PB + 1;
    localparam int DEPTH = OUT + 1;

    localparam logic [63:0] INV_GAIN = so3em_pkg::inv_gain(CORDIC_STAGES);

    so3em_pkg::item_t pipe_reg  [DEPTH];
    so3em_pkg::item_t pipe_next [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [30:0]      thresh_reg;
    logic             adv;
    logic [31:0]      rnd_w;
    logic [2:0][31:0] rnd_v;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == so3em_pkg::REG_THRESH) ? {1'b0, thresh_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= so3em_pkg::THRESH_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == so3em_pkg::REG_THRESH)
            thresh_reg <= pwdata[30:0];
    end

    // ---------------- flow control ----------------
    assign adv           = !vld_reg[OUT] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[OUT];
    assign m_axis_tdata  = pipe_reg[OUT].quat;
    assign m_axis_tuser  = pipe_reg[OUT].ident;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEPTH; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    // ---------------- magnitudes and squares ----------------
    always_comb
    begin
        logic [31:0] v;
        pipe_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            v = s_axis_tdata[32*i +: 32];
            pipe_next[0].neg[i] = v[31];
            pipe_next[0].mag[i] = v[31] ? (~v + 32'd1) : v;
            pipe_next[0].sq[i]  = 64'(pipe_next[0].mag[i]) * 64'(pipe_next[0].mag[i]);
        end
    end

    always_comb
    begin
        pipe_next[1]      = pipe_reg[0];
        pipe_next[1].rad  = pipe_reg[0].sq[0] + pipe_reg[0].sq[1] + pipe_reg[0].sq[2];
        pipe_next[1].root = 64'd0;
    end

    // ---------------- integer square root, one result bit per stage ----------------
    for (genvar k = 0; k < so3em_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        always_comb
        begin
            logic [63:0] trial;
            pipe_next[SQ0+k] = pipe_reg[SQ0+k-1];
            trial = pipe_reg[SQ0+k-1].root + BIT;
            if (pipe_reg[SQ0+k-1].rad >= trial)
            begin
                pipe_next[SQ0+k].rad  = pipe_reg[SQ0+k-1].rad - trial;
                pipe_next[SQ0+k].root = (pipe_reg[SQ0+k-1].root >> 1) + BIT;
            end
            else
            begin
                pipe_next[SQ0+k].root = pipe_reg[SQ0+k-1].root >> 1;
            end
        end
    end

    // zero angle always takes the identity path, as do angles below the threshold
    always_comb
    begin
        logic [31:0] ang;
        pipe_next[TH] = pipe_reg[TH-1];
        ang = pipe_reg[TH-1].root[31:0];
        pipe_next[TH].ident = (ang == 32'd0) || ({1'b0, thresh_reg} > ang);
        pipe_next[TH].r     = 64'd0;
    end

    // ---------------- half angle mod 2*pi, and direction ratios ----------------
    for (genvar k = 0; k < DM_STAGES; k++)
    begin : g_dm
        localparam int ABIT = (k < so3em_pkg::ANGLE_STEPS) ? (32 - k) : 0;
        always_comb
        begin
            so3em_pkg::item_t p;
            logic [63:0] rr;
            logic [32:0] ang;
            logic [32:0] rm;
            p   = pipe_reg[DM0+k-1];
            ang = {1'b0, p.root[31:0]};
            rr  = 64'd0;
            rm  = 33'd0;
            pipe_next[DM0+k] = p;
            if (k < MOD_STEPS)
            begin
                rr = so3em_pkg::mod_double(p.r);
                if (k < so3em_pkg::ANGLE_STEPS)
                begin
                    rr = rr + 64'(p.root[ABIT]);
                    if (rr >= so3em_pkg::TWO_PI_Q61)
                        rr = rr - so3em_pkg::TWO_PI_Q61;
                end
                pipe_next[DM0+k].r = rr;
            end
            if (k < so3em_pkg::DIV_STEPS)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (k == 0)
                    begin
                        rm = {1'b0, p.mag[i]};
                        pipe_next[DM0+k].quo[i] = 62'd0;
                    end
                    else
                    begin
                        rm = {p.rem[i][31:0], 1'b0};
                        pipe_next[DM0+k].quo[i] = {p.quo[i][60:0], 1'b0};
                    end
                    if (rm >= ang)
                    begin
                        rm = rm - ang;
                        pipe_next[DM0+k].quo[i][0] = 1'b1;
                    end
                    pipe_next[DM0+k].rem[i] = rm;
                end
            end
        end
    end

    // fold into [-pi/2, pi/2] and seed the CORDIC
    always_comb
    begin
        logic [63:0] a;
        logic        fl;
        pipe_next[FD] = pipe_reg[FD-1];
        a  = (pipe_reg[FD-1].r > so3em_pkg::PI_Q61) ?
             (pipe_reg[FD-1].r - so3em_pkg::TWO_PI_Q61) : pipe_reg[FD-1].r;
        fl = 1'b0;
        if (!a[63] && a > so3em_pkg::HALF_PI_Q61)
        begin
            a  = a - so3em_pkg::PI_Q61;
            fl = 1'b1;
        end
        else if (a[63] && (64'd0 - a) > so3em_pkg::HALF_PI_Q61)
        begin
            a  = a + so3em_pkg::PI_Q61;
            fl = 1'b1;
        end
        pipe_next[FD].flip = fl;
        pipe_next[FD].cx   = INV_GAIN;
        pipe_next[FD].cy   = 64'd0;
        pipe_next[FD].cz   = a;
    end

    // ---------------- rotation CORDIC ----------------
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        localparam logic [63:0] ATAN = so3em_pkg::arc_entry(i);
        always_comb
        begin
            logic [63:0] dx;
            logic [63:0] dy;
            pipe_next[CR0+i] = pipe_reg[CR0+i-1];
            dx = 64'($signed(pipe_reg[CR0+i-1].cy) >>> i);
            dy = 64'($signed(pipe_reg[CR0+i-1].cx) >>> i);
            if (!pipe_reg[CR0+i-1].cz[63])
            begin
                pipe_next[CR0+i].cx = pipe_reg[CR0+i-1].cx - dx;
                pipe_next[CR0+i].cy = pipe_reg[CR0+i-1].cy + dy;
                pipe_next[CR0+i].cz = pipe_reg[CR0+i-1].cz - ATAN;
            end
            else
            begin
                pipe_next[CR0+i].cx = pipe_reg[CR0+i-1].cx + dx;
                pipe_next[CR0+i].cy = pipe_reg[CR0+i-1].cy - dy;
                pipe_next[CR0+i].cz = pipe_reg[CR0+i-1].cz + ATAN;
            end
        end
    end

    // ---------------- signs, products, rounding ----------------
    always_comb
    begin
        logic [63:0] cv;
        logic [63:0] sv;
        pipe_next[SG] = pipe_reg[SG-1];
        cv = pipe_reg[SG-1].flip ? (64'd0 - pipe_reg[SG-1].cx) : pipe_reg[SG-1].cx;
        sv = pipe_reg[SG-1].flip ? (64'd0 - pipe_reg[SG-1].cy) : pipe_reg[SG-1].cy;
        pipe_next[SG].cneg = cv[63];
        pipe_next[SG].cmag = cv[63] ? (64'd0 - cv) : cv;
        pipe_next[SG].sneg = sv[63];
        pipe_next[SG].smag = sv[63] ? (64'd0 - sv) : sv;
    end

    // split sine magnitude times ratio into 32x32 partial products
    always_comb
    begin
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] b0;
        logic [31:0] b1;
        pipe_next[PA] = pipe_reg[SG];
        a0 = pipe_reg[SG].smag[31:0];
        a1 = pipe_reg[SG].smag[63:32];
        for (int i = 0; i < 3; i++)
        begin
            b0 = pipe_reg[SG].quo[i][31:0];
            b1 = {2'b00, pipe_reg[SG].quo[i][61:32]};
            pipe_next[PA].pp[i][0] = 64'(a0) * 64'(b0);
            pipe_next[PA].pp[i][1] = 64'(a0) * 64'(b1);
            pipe_next[PA].pp[i][2] = 64'(a1) * 64'(b0);
            pipe_next[PA].pp[i][3] = 64'(a1) * 64'(b1);
        end
    end

    always_comb
    begin
        logic [127:0] full;
        pipe_next[PB] = pipe_reg[PA];
        for (int i = 0; i < 3; i++)
        begin
            full = {64'd0, pipe_reg[PA].pp[i][0]}
                 + {32'd0, pipe_reg[PA].pp[i][1], 32'd0}
                 + {32'd0, pipe_reg[PA].pp[i][2], 32'd0}
                 + {pipe_reg[PA].pp[i][3], 64'd0};
            pipe_next[PB].prod[i] = full[124:61];
        end
    end

    so3em_round #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_round_w (
        .neg   (!pipe_reg[PB].ident && pipe_reg[PB].cneg),
        .mag   (pipe_reg[PB].ident ? so3em_pkg::ONE_Q61 : pipe_reg[PB].cmag),
        .value (rnd_w)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_round
        so3em_round #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_round_v (
            .neg   (pipe_reg[PB].sneg != pipe_reg[PB].neg[i]),
            .mag   (pipe_reg[PB].prod[i]),
            .value (rnd_v[i])
        );
    end

    always_comb
    begin
        pipe_next[OUT] = pipe_reg[PB];
        pipe_next[OUT].quat[0] = rnd_w;
        for (int i = 0; i < 3; i++)
            pipe_next[OUT].quat[i+1] = pipe_reg[PB].ident ? 32'd0 : rnd_v[i];
    end

    // ---------------- assertions ----------------
    a_ident_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[127:32] == 96'd0)
        else $error("identity result with nonzero vector part");

    a_ident_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[31] && m_axis_tdata[31:0] != 32'd0)
        else $error("identity result with bad real part");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

endmodule
